FILE: hdl/lcd_controller_register_block_core_assert.svh
// Assertion macros shared by the LCD controller register block RTL.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef LCD_CONTROLLER_REGISTER_BLOCK_CORE_ASSERT_SVH
`define LCD_CONTROLLER_REGISTER_BLOCK_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define LCDC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define LCDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lcdc_pkg.sv
// Shared types and constants of the LCD controller register block.
// No dependencies; used by lcdc_regfile and the top level.
package lcdc_pkg;

    // Function codes of an input beat
    typedef logic [1:0] func_t;
    localparam func_t FUNC_READ  = 2'd0;
    localparam func_t FUNC_WRITE = 2'd1;
    localparam func_t FUNC_TICK  = 2'd2;

    // Status codes of a result beat
    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_SIZE = 2'd1;
    localparam status_t ST_ADDR = 2'd2;

    // Set/clear/toggle alias taken from offset bits [3:2]
    typedef logic [1:0] alias_t;
    localparam alias_t ALIAS_WRITE  = 2'd0;
    localparam alias_t ALIAS_SET    = 2'd1;
    localparam alias_t ALIAS_CLEAR  = 2'd2;
    localparam alias_t ALIAS_TOGGLE = 2'd3;

    // Register select taken from offset bits [7:4]
    typedef logic [3:0] reg_sel_t;
    localparam reg_sel_t SEL_CTRL0   = 4'h0;
    localparam reg_sel_t SEL_CTRL1   = 4'h1;
    localparam reg_sel_t SEL_CUR     = 4'h2;
    localparam reg_sel_t SEL_NEXT    = 4'h3;
    localparam reg_sel_t SEL_TIM0    = 4'h4;
    localparam reg_sel_t SEL_TIM1    = 4'h5;
    localparam reg_sel_t SEL_TIM2    = 4'h6;
    localparam reg_sel_t SEL_TIM3    = 4'h7;
    localparam reg_sel_t SEL_VD0     = 4'h8;
    localparam reg_sel_t SEL_VD1     = 4'h9;
    localparam reg_sel_t SEL_VD2     = 4'hA;
    localparam reg_sel_t SEL_VD3     = 4'hB;
    localparam reg_sel_t SEL_STAT    = 4'hC;
    localparam reg_sel_t SEL_VERSION = 4'hD;

    localparam logic [2:0]  ACCESS_WORD   = 3'd4;
    localparam logic [31:0] CTRL0_RESET   = 32'hC000_0000;
    localparam int          BIT_SOFTRESET = 31;
    localparam int          BIT_CLOCKGATE = 30;
    localparam int          BIT_RUN       = 0;
    localparam logic [2:0]  PEND_VSYNC    = 3'b001;
    localparam logic [31:0] STAT_WORD     = 32'h9400_0000;
    localparam logic [31:0] VERSION_WORD  = 32'h0100_0000;

    localparam int NUM_WORDS = 4;

    typedef struct packed {
        func_t       func;
        logic [12:0] offset;
        logic [31:0] write_data;
        logic [2:0]  access_size;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        status_t     status;
        logic        irq_line;
        logic        frame_fetch;
    } result_t;

endpackage

FILE: hdl/lcdc_regfile.sv
// Register file of the LCD controller: access decode, register state, tick logic.
// Depends on lcdc_pkg and lcd_controller_register_block_core_assert.svh.
`include "lcd_controller_register_block_core_assert.svh"

module lcdc_regfile
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_wr_data,
    input  logic             step,
    input  lcdc_pkg::item_t  item,
    output lcdc_pkg::result_t result
);

    logic [31:0] ctrl0_reg, ctrl0_next;
    logic [31:0] ctrl1_reg, ctrl1_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] next_buf_reg, next_buf_next;
    logic [31:0] tim_reg [lcdc_pkg::NUM_WORDS];
    logic [31:0] tim_next [lcdc_pkg::NUM_WORDS];
    logic [31:0] vd_reg [lcdc_pkg::NUM_WORDS];
    logic [31:0] vd_next [lcdc_pkg::NUM_WORDS];
    logic [2:0]  pend_reg, pend_next;
    logic [2:0]  irq_en_reg;

    logic                size_ok;
    logic                in_window;
    logic                sel_ok;
    logic                read_hit;
    logic                write_hit;
    lcdc_pkg::reg_sel_t  sel;
    lcdc_pkg::alias_t    mode;
    logic [1:0]          word_idx;
    logic                blk_enabled;
    logic [31:0]         rd_word;
    logic [31:0]         ctrl0_alias;

    // Apply a set/clear/toggle alias to a register value
    function automatic logic [31:0] alias_apply(logic [31:0] old, logic [31:0] v,
                                                lcdc_pkg::alias_t m);
        logic [31:0] r;
        case (m)
            lcdc_pkg::ALIAS_SET:    r = old | v;
            lcdc_pkg::ALIAS_CLEAR:  r = old & ~v;
            lcdc_pkg::ALIAS_TOGGLE: r = old ^ v;
            default:                r = v;
        endcase
        return r;
    endfunction

    // Decode the offset
    assign size_ok   = (item.access_size == lcdc_pkg::ACCESS_WORD);
    assign sel       = item.offset[7:4];
    assign mode      = item.offset[3:2];
    assign word_idx  = item.offset[5:4];
    assign in_window = (item.offset[12:8] == 5'd0) && (item.offset[1:0] == 2'd0);
    assign sel_ok    = (sel <= lcdc_pkg::SEL_VERSION);
    assign read_hit  = in_window && sel_ok && (item.offset[3:2] == 2'd0);
    assign write_hit = in_window && sel_ok;

    assign blk_enabled = !ctrl0_reg[lcdc_pkg::BIT_SOFTRESET]
                      && !ctrl0_reg[lcdc_pkg::BIT_CLOCKGATE]
                      && ctrl0_reg[lcdc_pkg::BIT_RUN];

    // Select the read word
    always_comb
    begin
        case (sel)
            lcdc_pkg::SEL_CTRL0:   rd_word = ctrl0_reg;
            lcdc_pkg::SEL_CTRL1:   rd_word = ctrl1_reg;
            lcdc_pkg::SEL_CUR:     rd_word = cur_reg;
            lcdc_pkg::SEL_NEXT:    rd_word = next_buf_reg;
            lcdc_pkg::SEL_TIM0,
            lcdc_pkg::SEL_TIM1,
            lcdc_pkg::SEL_TIM2,
            lcdc_pkg::SEL_TIM3:    rd_word = tim_reg[word_idx];
            lcdc_pkg::SEL_VD0,
            lcdc_pkg::SEL_VD1,
            lcdc_pkg::SEL_VD2,
            lcdc_pkg::SEL_VD3:     rd_word = vd_reg[word_idx];
            lcdc_pkg::SEL_STAT:    rd_word = lcdc_pkg::STAT_WORD;
            lcdc_pkg::SEL_VERSION: rd_word = lcdc_pkg::VERSION_WORD;
            default:               rd_word = 32'd0;
        endcase
    end

    // CTRL0 after alias, with the clock gate following soft reset
    always_comb
    begin
        ctrl0_alias = alias_apply(ctrl0_reg, item.write_data, mode);
        ctrl0_alias[lcdc_pkg::BIT_CLOCKGATE] = ctrl0_alias[lcdc_pkg::BIT_SOFTRESET];
    end

    // Next state and result of the current beat
    always_comb
    begin
        ctrl0_next    = ctrl0_reg;
        ctrl1_next    = ctrl1_reg;
        cur_next      = cur_reg;
        next_buf_next = next_buf_reg;
        tim_next      = tim_reg;
        vd_next       = vd_reg;
        pend_next     = pend_reg;
        result.read_data   = 32'd0;
        result.status      = lcdc_pkg::ST_OK;
        result.frame_fetch = 1'b0;

        case (item.func)
            lcdc_pkg::FUNC_READ:
            begin
                if (!size_ok)
                    result.status = lcdc_pkg::ST_SIZE;
                else if (!read_hit)
                    result.status = lcdc_pkg::ST_ADDR;
                else
                    result.read_data = rd_word;
            end
            lcdc_pkg::FUNC_WRITE:
            begin
                if (!size_ok)
                    result.status = lcdc_pkg::ST_SIZE;
                else if (!write_hit)
                    result.status = lcdc_pkg::ST_ADDR;
                else
                begin
                    case (sel)
                        lcdc_pkg::SEL_CTRL0: ctrl0_next = ctrl0_alias;
                        lcdc_pkg::SEL_CTRL1:
                            ctrl1_next = alias_apply(ctrl1_reg, item.write_data, mode);
                        lcdc_pkg::SEL_CUR:   cur_next = item.write_data;
                        lcdc_pkg::SEL_NEXT:
                        begin
                            next_buf_next = item.write_data;
                            cur_next      = item.write_data;
                        end
                        lcdc_pkg::SEL_TIM0,
                        lcdc_pkg::SEL_TIM1,
                        lcdc_pkg::SEL_TIM2,
                        lcdc_pkg::SEL_TIM3:  tim_next[word_idx] = item.write_data;
                        lcdc_pkg::SEL_VD0,
                        lcdc_pkg::SEL_VD1,
                        lcdc_pkg::SEL_VD2,
                        lcdc_pkg::SEL_VD3:   vd_next[word_idx] = item.write_data;
                        default: ;
                    endcase
                end
            end
            lcdc_pkg::FUNC_TICK:
            begin
                if (blk_enabled)
                begin
                    pend_next = pend_reg | lcdc_pkg::PEND_VSYNC;
                    result.frame_fetch = (tim_reg[0][15:0] != 16'd0)
                                      && (tim_reg[1][15:0] != 16'd0)
                                      && (cur_reg != 32'd0);
                end
            end
            default: ;
        endcase

        result.irq_line = |(pend_next & irq_en_reg);
    end

    // Hold the enable mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            irq_en_reg <= 3'd0;
        else if (cfg_wr_en)
            irq_en_reg <= cfg_wr_data;
    end

    // Commit register state when the beat advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg    <= lcdc_pkg::CTRL0_RESET;
            ctrl1_reg    <= 32'd0;
            cur_reg      <= 32'd0;
            next_buf_reg <= 32'd0;
            for (int i = 0; i < lcdc_pkg::NUM_WORDS; i++)
            begin
                tim_reg[i] <= 32'd0;
                vd_reg[i]  <= 32'd0;
            end
            pend_reg     <= 3'd0;
        end
        else if (step)
        begin
            ctrl0_reg    <= ctrl0_next;
            ctrl1_reg    <= ctrl1_next;
            cur_reg      <= cur_next;
            next_buf_reg <= next_buf_next;
            tim_reg      <= tim_next;
            vd_reg       <= vd_next;
            pend_reg     <= pend_next;
        end
    end

    `LCDC_ASSERT(a_clkgate_follows, ctrl0_reg[30] == ctrl0_reg[31], "clock gate differs from soft reset")
    `LCDC_ASSERT_NEXT(a_vsync_sticky, pend_reg[0], pend_reg[0], "vsync pending bit cleared")
    `LCDC_ASSERT(a_pend_only_vsync, pend_reg[2:1] == 2'b00, "non-vsync pending bit set")
    `LCDC_ASSERT(a_fetch_on_tick, !result.frame_fetch || (item.func == lcdc_pkg::FUNC_TICK), "fetch without tick")

endmodule

FILE: hdl/lcd_controller_register_block_core.sv
// Top level of the LCD controller register block: input and result registers.
// Depends on lcdc_pkg, lcdc_regfile and lcd_controller_register_block_core_assert.svh.
//
// Usage:
//   s_axis carries one bus read, bus write or refresh tick per beat; tuser holds
//   the function code, tdata the offset, write data and access size.
//   m_axis returns exactly one result beat per input beat, in order; tuser holds
//   the status code, tdata the read data, interrupt line and frame-fetch flag.
//   cfg_wr_en/cfg_wr_data load the 3-bit interrupt enable mask; write it only
//   while no beat is in flight.
//   Path: an accepted beat is held in the input register; when it advances, its
//   result is registered in the result register and offered on m_axis.
//   Throughput: one beat per cycle while the result is not stalled; the register
//   file decodes and updates its state as a beat moves from input to result register.
//   Stall: when m_axis_tready is low the result holds, the input register keeps
//   one more beat, and s_axis_tready drops once both are full.
//   Reset: rst_n clears both valid flags, the enable mask and the register file state;
//   CTRL0 comes up with soft reset and clock gate set.
`include "lcd_controller_register_block_core_assert.svh"

module lcd_controller_register_block_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // offset[12:0], write_data[44:13], access_size[47:45]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // read_data[31:0], irq_line[32], frame_fetch[33], zero
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data    // irq_enable_mask
);

    logic              in_valid_reg, in_valid_next;
    lcdc_pkg::item_t   in_item_reg;
    logic              out_valid_reg, out_valid_next;
    lcdc_pkg::result_t out_res_reg;
    lcdc_pkg::result_t res;
    logic              s_fire;
    logic              advance;

    // Handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat and the result
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.func        <= s_axis_tuser;
            in_item_reg.offset      <= s_axis_tdata[12:0];
            in_item_reg.write_data  <= s_axis_tdata[44:13];
            in_item_reg.access_size <= s_axis_tdata[47:45];
        end
        if (advance)
            out_res_reg <= res;
    end

    lcdc_regfile u_regfile
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (in_item_reg),
        .result      (res)
    );

    // Drive the result channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.status;
    assign m_axis_tdata  = {6'd0, out_res_reg.frame_fetch, out_res_reg.irq_line,
                            out_res_reg.read_data};

    `LCDC_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg, "stalled input beat lost")
    `LCDC_ASSERT_NEXT(a_out_held, out_valid_reg && !m_axis_tready, out_valid_reg, "stalled result lost")

endmodule
